// File: rtl/afc_pkg.sv
// shared types and constants for the box against frustum culling block
package afc_pkg;

  localparam int PlaneCount = 6;
  localparam int IdxW       = 3;
  localparam int CoordW     = 32;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = CoordW + DiffW;
  localparam int SumW       = ProdW + 2;
  localparam int VisW       = 2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTest = 1'b1;

  localparam logic [VisW-1:0] VisInvisible = 2'd0;
  localparam logic [VisW-1:0] VisPartial   = 2'd1;
  localparam logic [VisW-1:0] VisVisible   = 2'd2;

  // one beat as it travels along the row of plane cells
  typedef struct packed {
    logic                     valid;
    logic                     opcode;
    logic [IdxW-1:0]          plane_index;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic                     any_out;
    logic                     any_part;
  } beat_t;

endpackage

// File: rtl/afc_cell.sv
// one plane cell: holds a plane, captures loads for it and tests passing boxes
module afc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [afc_pkg::IdxW-1:0]       cell_idx_i,
  input  logic                           adv_i,
  input  afc_pkg::beat_t                 beat_i,
  output afc_pkg::beat_t                 beat_o
);

  logic signed [afc_pkg::CoordW-1:0] pnt_q [3];
  logic signed [afc_pkg::CoordW-1:0] nrm_q [3];
  logic signed [afc_pkg::CoordW-1:0] box_min [3];
  logic signed [afc_pkg::CoordW-1:0] box_max [3];
  logic signed [afc_pkg::CoordW-1:0] v_pos [3];
  logic signed [afc_pkg::CoordW-1:0] v_neg [3];
  logic signed [afc_pkg::DiffW-1:0]  d_pos [3];
  logic signed [afc_pkg::DiffW-1:0]  d_neg [3];
  logic signed [afc_pkg::ProdW-1:0]  prod_pos_d [3];
  logic signed [afc_pkg::ProdW-1:0]  prod_neg_d [3];
  logic signed [afc_pkg::ProdW-1:0]  prod_pos_q [3];
  logic signed [afc_pkg::ProdW-1:0]  prod_neg_q [3];
  logic signed [afc_pkg::SumW-1:0]   sum_pos;
  logic signed [afc_pkg::SumW-1:0]   sum_neg;
  afc_pkg::beat_t                    mid_q;
  afc_pkg::beat_t                    out_d;
  afc_pkg::beat_t                    out_q;
  logic                              load_hit;

  assign load_hit = beat_i.valid && (beat_i.opcode == afc_pkg::OpLoad) &&
                    (beat_i.plane_index == cell_idx_i);

  assign box_min[0] = beat_i.a_x;
  assign box_min[1] = beat_i.a_y;
  assign box_min[2] = beat_i.a_z;
  assign box_max[0] = beat_i.b_x;
  assign box_max[1] = beat_i.b_y;
  assign box_max[2] = beat_i.b_z;

  // zero normal component counts as non-negative
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v_pos[k] = nrm_q[k][afc_pkg::CoordW-1] ? box_min[k] : box_max[k];
      v_neg[k] = nrm_q[k][afc_pkg::CoordW-1] ? box_max[k] : box_min[k];
      d_pos[k] = $signed({v_pos[k][afc_pkg::CoordW-1], v_pos[k]}) -
                 $signed({pnt_q[k][afc_pkg::CoordW-1], pnt_q[k]});
      d_neg[k] = $signed({v_neg[k][afc_pkg::CoordW-1], v_neg[k]}) -
                 $signed({pnt_q[k][afc_pkg::CoordW-1], pnt_q[k]});
      prod_pos_d[k] = afc_pkg::ProdW'(nrm_q[k]) * afc_pkg::ProdW'(d_pos[k]);
      prod_neg_d[k] = afc_pkg::ProdW'(nrm_q[k]) * afc_pkg::ProdW'(d_neg[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        pnt_q[k] <= '0;
        nrm_q[k] <= '0;
      end
    end else if (adv_i && load_hit) begin
      pnt_q[0] <= beat_i.a_x;
      pnt_q[1] <= beat_i.a_y;
      pnt_q[2] <= beat_i.a_z;
      nrm_q[0] <= beat_i.b_x;
      nrm_q[1] <= beat_i.b_y;
      nrm_q[2] <= beat_i.b_z;
    end
  end

  // exact three-term sums, only the sign is kept
  always_comb begin
    sum_pos = afc_pkg::SumW'(prod_pos_q[0]) + afc_pkg::SumW'(prod_pos_q[1]) +
              afc_pkg::SumW'(prod_pos_q[2]);
    sum_neg = afc_pkg::SumW'(prod_neg_q[0]) + afc_pkg::SumW'(prod_neg_q[1]) +
              afc_pkg::SumW'(prod_neg_q[2]);
    out_d          = mid_q;
    out_d.any_out  = mid_q.any_out  | sum_pos[afc_pkg::SumW-1];
    out_d.any_part = mid_q.any_part | sum_neg[afc_pkg::SumW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
      for (int k = 0; k < 3; k++) begin
        prod_pos_q[k] <= '0;
        prod_neg_q[k] <= '0;
      end
    end else if (adv_i) begin
      mid_q <= beat_i;
      out_q <= out_d;
      for (int k = 0; k < 3; k++) begin
        prod_pos_q[k] <= prod_pos_d[k];
        prod_neg_q[k] <= prod_neg_d[k];
      end
    end
  end

  assign beat_o = out_q;

endmodule

// File: rtl/aabb_frustum_cull.sv
// Box against frustum culling: a row of six plane cells, one per frustum plane.
// Every beat, load or test, walks the row in order through the product and
// output registers of each cell: a load is captured by the cell whose index
// it names (out of range it is dropped), a test picks positive and negative
// vertices in each cell, forms the exact signed distances (33-bit differences,
// 65-bit products, 67-bit sums) and ORs their signs into outside and partial
// flags. One beat is accepted per cycle unless the row holds; a test answers
// through a result register. Loads give no result and are seen by every later
// test. The whole row holds only while a finished test waits behind a full
// result register. Planes reset to zero, so an unloaded block answers visible.
module aabb_frustum_cull (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [afc_pkg::IdxW-1:0]          plane_index_i,
  input  logic signed [afc_pkg::CoordW-1:0] a_x_i,
  input  logic signed [afc_pkg::CoordW-1:0] a_y_i,
  input  logic signed [afc_pkg::CoordW-1:0] a_z_i,
  input  logic signed [afc_pkg::CoordW-1:0] b_x_i,
  input  logic signed [afc_pkg::CoordW-1:0] b_y_i,
  input  logic signed [afc_pkg::CoordW-1:0] b_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [afc_pkg::VisW-1:0]          visibility_o
);

  afc_pkg::beat_t            chain [afc_pkg::PlaneCount+1];
  afc_pkg::beat_t            tail;
  logic                      adv;
  logic                      tail_test;
  logic                      out_valid_q;
  logic [afc_pkg::VisW-1:0]  vis_q;
  logic [afc_pkg::VisW-1:0]  vis_d;

  always_comb begin
    chain[0].valid       = in_valid_i;
    chain[0].opcode      = opcode_i;
    chain[0].plane_index = plane_index_i;
    chain[0].a_x         = a_x_i;
    chain[0].a_y         = a_y_i;
    chain[0].a_z         = a_z_i;
    chain[0].b_x         = b_x_i;
    chain[0].b_y         = b_y_i;
    chain[0].b_z         = b_z_i;
    chain[0].any_out     = 1'b0;
    chain[0].any_part    = 1'b0;
  end

  for (genvar i = 0; i < afc_pkg::PlaneCount; i++) begin : g_cell
    afc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (afc_pkg::IdxW'(i)),
      .adv_i      (adv),
      .beat_i     (chain[i]),
      .beat_o     (chain[i+1])
    );
  end

  assign tail      = chain[afc_pkg::PlaneCount];
  assign tail_test = tail.valid && (tail.opcode == afc_pkg::OpTest);

  // hold the row only when a finished test has nowhere to go
  assign adv        = !(tail_test && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;

  always_comb begin
    priority if (tail.any_out) begin
      vis_d = afc_pkg::VisInvisible;
    end else if (tail.any_part) begin
      vis_d = afc_pkg::VisPartial;
    end else begin
      vis_d = afc_pkg::VisVisible;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && tail_test) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tail_test) begin
      vis_q <= vis_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign visibility_o = vis_q;

endmodule

// File: rtl/afc_checker.sv
// port-level checks for the culling block, bound to its top level
module afc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [afc_pkg::VisW-1:0] visibility_o
);

  // a result beat waits until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(visibility_o))
    else $error("result beat changed while stalled");

  // input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visibility_o <= afc_pkg::VisVisible))
    else $error("visibility code out of range");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (.*);

// File: dv/aabb_frustum_cull_tb.sv
// self-checking testbench for the box against frustum culling block
module aabb_frustum_cull_tb;

  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int ItemTarget  = 1900;

  localparam logic signed [afc_pkg::CoordW-1:0] CMin = 32'sh8000_0000;
  localparam logic signed [afc_pkg::CoordW-1:0] CMax = 32'sh7fff_ffff;
  localparam logic signed [afc_pkg::CoordW-1:0] One  = 32'sh0001_0000;

  typedef struct {
    logic                              opcode;
    logic [afc_pkg::IdxW-1:0]          plane_index;
    logic signed [afc_pkg::CoordW-1:0] a_x, a_y, a_z;
    logic signed [afc_pkg::CoordW-1:0] b_x, b_y, b_z;
  } cull_item_t;

  typedef struct {
    logic signed [afc_pkg::CoordW-1:0] px, py, pz;
    logic signed [afc_pkg::CoordW-1:0] nx, ny, nz;
  } plane_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic                              opcode_i      = afc_pkg::OpLoad;
  logic [afc_pkg::IdxW-1:0]          plane_index_i = '0;
  logic signed [afc_pkg::CoordW-1:0] a_x_i         = '0;
  logic signed [afc_pkg::CoordW-1:0] a_y_i         = '0;
  logic signed [afc_pkg::CoordW-1:0] a_z_i         = '0;
  logic signed [afc_pkg::CoordW-1:0] b_x_i         = '0;
  logic signed [afc_pkg::CoordW-1:0] b_y_i         = '0;
  logic signed [afc_pkg::CoordW-1:0] b_z_i         = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic [afc_pkg::VisW-1:0]          visibility_o;

  cull_item_t               pending_beats[$];
  logic [afc_pkg::VisW-1:0] expected_vis[$];
  plane_t                   plane_store[afc_pkg::PlaneCount];

  cull_item_t               next_item;
  cull_item_t               seen_item;
  logic [afc_pkg::VisW-1:0] want_vis;
  logic                     beat_taken     = 1'b0;
  int                       item_total     = 0;
  int                       err_count      = 0;
  int                       cycle_count    = 0;
  int                       in_idle_left   = 0;
  int                       in_calm_left   = 0;
  int                       out_stall_left = 0;
  int                       out_calm_left  = 0;

  aabb_frustum_cull DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .plane_index_i (plane_index_i),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .a_z_i         (a_z_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .b_z_i         (b_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .visibility_o  (visibility_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // exact sign of n . (v - p), computed at the hardware's sum width
  function automatic logic below_plane(plane_t pl,
                                       logic signed [afc_pkg::CoordW-1:0] vx,
                                       logic signed [afc_pkg::CoordW-1:0] vy,
                                       logic signed [afc_pkg::CoordW-1:0] vz);
    logic signed [afc_pkg::SumW-1:0] dx, dy, dz, nx, ny, nz, dsum;
    dx = vx;
    dy = vy;
    dz = vz;
    dx = dx - pl.px;
    dy = dy - pl.py;
    dz = dz - pl.pz;
    nx = pl.nx;
    ny = pl.ny;
    nz = pl.nz;
    dsum = nx * dx + ny * dy + nz * dz;
    return dsum[afc_pkg::SumW-1];
  endfunction

  function automatic logic [afc_pkg::VisW-1:0] predict_visibility(cull_item_t it);
    logic any_out, any_part;
    logic signed [afc_pkg::CoordW-1:0] hx, hy, hz, lx, ly, lz;
    any_out  = 1'b0;
    any_part = 1'b0;
    for (int i = 0; i < afc_pkg::PlaneCount; i++) begin
      // a zero normal component counts as non-negative
      hx = plane_store[i].nx[afc_pkg::CoordW-1] ? it.a_x : it.b_x;
      hy = plane_store[i].ny[afc_pkg::CoordW-1] ? it.a_y : it.b_y;
      hz = plane_store[i].nz[afc_pkg::CoordW-1] ? it.a_z : it.b_z;
      lx = plane_store[i].nx[afc_pkg::CoordW-1] ? it.b_x : it.a_x;
      ly = plane_store[i].ny[afc_pkg::CoordW-1] ? it.b_y : it.a_y;
      lz = plane_store[i].nz[afc_pkg::CoordW-1] ? it.b_z : it.a_z;
      if (below_plane(plane_store[i], hx, hy, hz)) any_out = 1'b1;
      if (below_plane(plane_store[i], lx, ly, lz)) any_part = 1'b1;
    end
    if (any_out) return afc_pkg::VisInvisible;
    if (any_part) return afc_pkg::VisPartial;
    return afc_pkg::VisVisible;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // uniform in [-m, m]
  function automatic int spread(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  task automatic push_beat(int op, int idx, int ax, int ay, int az,
                           int bx, int by, int bz);
    cull_item_t it;
    it.opcode      = op[0];
    it.plane_index = idx[afc_pkg::IdxW-1:0];
    it.a_x = ax;
    it.a_y = ay;
    it.a_z = az;
    it.b_x = bx;
    it.b_y = by;
    it.b_z = bz;
    pending_beats.push_back(it);
    if (it.opcode == afc_pkg::OpTest || idx < afc_pkg::PlaneCount) item_total++;
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || beat_taken) begin
        if (in_idle_left > 0) begin
          in_valid_i <= 1'b0;
          in_idle_left--;
        end else if (pending_beats.size() != 0) begin
          next_item = pending_beats.pop_front();
          opcode_i      <= next_item.opcode;
          plane_index_i <= next_item.plane_index;
          a_x_i         <= next_item.a_x;
          a_y_i         <= next_item.a_y;
          a_z_i         <= next_item.a_z;
          b_x_i         <= next_item.b_x;
          b_y_i         <= next_item.b_y;
          b_z_i         <= next_item.b_z;
          in_valid_i    <= 1'b1;
          if (in_calm_left > 0) begin
            in_calm_left--;
          end else begin
            in_idle_left = pick_gap();
            if ($urandom_range(0, 49) == 0) in_calm_left = $urandom_range(20, 150);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall_left > 0) begin
        out_ready_i <= 1'b0;
        out_stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_calm_left > 0) out_calm_left--;
        else if ($urandom_range(0, 99) < 30) out_stall_left = pick_gap();
        else if ($urandom_range(0, 199) == 0) out_calm_left = $urandom_range(50, 300);
      end
    end
  end

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      beat_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        seen_item.opcode      = opcode_i;
        seen_item.plane_index = plane_index_i;
        seen_item.a_x = a_x_i;
        seen_item.a_y = a_y_i;
        seen_item.a_z = a_z_i;
        seen_item.b_x = b_x_i;
        seen_item.b_y = b_y_i;
        seen_item.b_z = b_z_i;
        if (seen_item.opcode == afc_pkg::OpLoad) begin
          if (seen_item.plane_index < afc_pkg::PlaneCount)
            plane_store[seen_item.plane_index] = '{seen_item.a_x, seen_item.a_y,
                                                   seen_item.a_z, seen_item.b_x,
                                                   seen_item.b_y, seen_item.b_z};
        end else begin
          expected_vis.push_back(predict_visibility(seen_item));
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_vis.size() == 0) begin
          report_mismatch($sformatf("visibility %0d with nothing expected", visibility_o));
        end else begin
          want_vis = expected_vis.pop_front();
          if (visibility_o !== want_vis)
            report_mismatch($sformatf("visibility %0d, expected %0d", visibility_o, want_vis));
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int roll, half, mag, n_tests, ax, tmp;
    int pv[3], nv[3], lo[3], hi[3];

    foreach (plane_store[i]) plane_store[i] = '{default: '0};

    // untouched planes answer visible, even for the widest and an inverted box
    push_beat(afc_pkg::OpTest, 0, CMin, CMin, CMin, CMax, CMax, CMax);
    push_beat(afc_pkg::OpTest, 7, CMax, CMax, CMax, CMin, CMin, CMin);
    // half-space x >= 0
    push_beat(afc_pkg::OpLoad, 0, 0, 0, 0, One, 0, 0);
    push_beat(afc_pkg::OpTest, 3, One, -One, -One, 2 * One, One, One);
    push_beat(afc_pkg::OpTest, 1, -2 * One, -One, -One, -One, One, One);
    push_beat(afc_pkg::OpTest, 2, -One, -One, -One, One, One, One);
    // slab 0 <= x <= 1
    push_beat(afc_pkg::OpLoad, 1, One, 0, 0, -One, 0, 0);
    push_beat(afc_pkg::OpTest, 0, One / 2, 0, 0, 2 * One, One, One);
    push_beat(afc_pkg::OpTest, 0, One / 4, 0, 0, One / 2, One, One);
    // out-of-range loads must leave the planes alone
    push_beat(afc_pkg::OpLoad, 6, 0, 0, 0, -One, -One, -One);
    push_beat(afc_pkg::OpLoad, 7, CMax, CMax, CMax, CMin, CMin, CMin);
    push_beat(afc_pkg::OpTest, 5, One / 4, 0, 0, One / 2, One, One);
    // extreme points and normals, largest products
    push_beat(afc_pkg::OpLoad, 2, CMin, CMin, CMin, CMin, CMax, CMin);
    push_beat(afc_pkg::OpTest, 4, CMin, CMin, CMin, CMax, CMax, CMax);
    push_beat(afc_pkg::OpLoad, 3, CMax, CMax, CMax, CMax, CMin, 0);
    push_beat(afc_pkg::OpTest, 6, CMin, CMin, CMin, CMax, CMax, CMax);
    push_beat(afc_pkg::OpTest, 0, 0, 0, 0, 0, 0, 0);
    // zero normal gives zero distance
    push_beat(afc_pkg::OpLoad, 4, CMax, CMin, CMax, 0, 0, 0);
    push_beat(afc_pkg::OpLoad, 5, 0, 0, 0, 0, One, 0);
    push_beat(afc_pkg::OpTest, 1, One / 4, 0, 0, One / 2, One, 0);
    push_beat(afc_pkg::OpTest, 2, One / 2, 0, 0, One / 4, One, 0);
    push_beat(afc_pkg::OpTest, 3, One / 4, -One, 0, One / 2, 0, 0);
    push_beat(afc_pkg::OpTest, 7, One / 4, -One, CMin, One / 2, -One / 2, CMax);

    while (item_total < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // box-shaped frustum with tilted walls, then boxes scattered around it
        half = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << 16)
                                           : $urandom_range(1, 2000) << 16;
        for (int p = 0; p < afc_pkg::PlaneCount; p++) begin
          mag = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32'h7fff_ffff)
                                            : $urandom_range(1, 1 << 18);
          for (int k = 0; k < 3; k++) begin
            if (k == p / 2) begin
              nv[k] = (p % 2) ? -mag : mag;
              pv[k] = ((p % 2) ? half : -half) + spread(half / 16);
            end else begin
              nv[k] = ($urandom_range(0, 3) == 0) ? 0 : spread(mag / 4);
              pv[k] = spread(half / 16);
            end
          end
          push_beat(afc_pkg::OpLoad, p, pv[0], pv[1], pv[2], nv[0], nv[1], nv[2]);
        end
        n_tests = $urandom_range(4, 20);
        for (int t = 0; t < n_tests; t++) begin
          for (int k = 0; k < 3; k++) begin
            tmp   = spread(2 * half);
            mag   = $urandom_range(0, half);
            lo[k] = tmp - mag;
            hi[k] = tmp + mag;
          end
          if ($urandom_range(0, 15) == 0) begin
            ax = $urandom_range(0, 2);
            tmp = lo[ax];
            lo[ax] = hi[ax];
            hi[ax] = tmp;
          end
          if ($urandom_range(0, 9) == 0)
            push_beat(afc_pkg::OpLoad, $urandom_range(6, 7), $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
          push_beat(afc_pkg::OpTest, $urandom_range(0, 7), lo[0], lo[1], lo[2],
                    hi[0], hi[1], hi[2]);
        end
      end else if (roll < 90) begin
        push_beat($urandom_range(0, 1), $urandom_range(0, 7), $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 2))
          0: push_beat(afc_pkg::OpLoad, $urandom_range(6, 7), $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
          1: begin
            push_beat(afc_pkg::OpLoad, $urandom_range(0, afc_pkg::PlaneCount - 1),
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            push_beat(afc_pkg::OpTest, $urandom_range(0, 7), $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
          end
          default: begin
            // degenerate box, a single point
            lo[0] = $urandom;
            lo[1] = $urandom;
            lo[2] = $urandom;
            push_beat(afc_pkg::OpTest, $urandom_range(0, 7), lo[0], lo[1], lo[2],
                      lo[0], lo[1], lo[2]);
          end
        endcase
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_vis.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_vis.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_vis.size()));

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
